// ----- rtl/energy_voice_gate_with_preroll_unit_defines.svh -----
//------------------------------------------------------------------------------
// Voice gate assertion macros
// Concurrent assertion wrappers shared by the voice gate RTL. Define
// NO_ASSERTIONS to compile them away.
//------------------------------------------------------------------------------
`ifndef ENERGY_VOICE_GATE_WITH_PREROLL_UNIT_DEFINES_SVH
`define ENERGY_VOICE_GATE_WITH_PREROLL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EVG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("voice gate assertion failed");
`define EVG_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("voice gate assertion failed");
`else
`define EVG_ASSERT(lbl, clk, rst_n, prop)
`define EVG_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

// ----- rtl/evg_pkg.sv -----
//------------------------------------------------------------------------------
// Voice gate package
// Register indexes, command format between the front and back parts, and
// the back part's state encoding.
//------------------------------------------------------------------------------
package evg_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int TIME_W      = 48;
    localparam int QUEUE_DEPTH = 4;
    localparam int CMD_FIRST_W = 4;
    localparam int CMD_FILL_W  = 5;

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HOLD      = 2'd1;
    localparam logic [1:0] REG_DEBOUNCE  = 2'd2;

    typedef enum logic {
        CMD_PASS,
        CMD_REPLAY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                kind;
        logic [SAMPLE_W-1:0]      sample;
        logic [CMD_FIRST_W-1:0]   first;
        logic [CMD_FILL_W-1:0]    fill;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } t_back_state;

endpackage

// ----- rtl/evg_ram.sv -----
//------------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
//------------------------------------------------------------------------------
module evg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/evg_queue.sv -----
//------------------------------------------------------------------------------
// Voice gate command queue
// Short register queue that decouples the classifier from the output side.
//------------------------------------------------------------------------------
`include "energy_voice_gate_with_preroll_unit_defines.svh"

module evg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  evg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output evg_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    localparam int QD    = evg_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_W = $clog2(QD + 1);

    evg_pkg::t_cmd    r_mem [QD];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QD));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QD - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QD - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `EVG_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, i_push |-> !o_full)
    `EVG_ASSERT(a_queue_no_underflow, i_clk, i_rst_n, i_pop |-> !o_empty)

endmodule

// ----- rtl/evg_front.sv -----
//------------------------------------------------------------------------------
// Voice gate front end
// Accepts samples, accumulates frame energy, runs the gate decision, writes
// the preroll ring while the gate is closed and queues output commands.
//------------------------------------------------------------------------------
`include "energy_voice_gate_with_preroll_unit_defines.svh"

module evg_front #(
    parameter int FS = 16,
    parameter int PF = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [evg_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [evg_pkg::TIME_W-1:0]           i_time,
    input  logic [16+$clog2(FS+1)-1:0]           i_thr_scaled,
    input  logic [31:0]                          i_hold,
    input  logic [7:0]                           i_debounce,
    input  logic                                 i_q_full,
    output logic                                 o_push,
    output evg_pkg::t_cmd                        o_cmd,
    output logic                                 o_wr_en,
    output logic [(PF*FS > 1 ? $clog2(PF*FS) : 1)-1:0] o_wr_addr,
    output logic [evg_pkg::SAMPLE_W-1:0]         o_wr_data,
    input  logic                                 i_replay_done
);

    localparam int SUM_W  = 16 + $clog2(FS + 1);
    localparam int POS_W  = (FS > 1) ? $clog2(FS) : 1;
    localparam int SLOT_W = (PF > 1) ? $clog2(PF) : 1;
    localparam int FILL_W = $clog2(PF + 1);
    localparam int FSUM_W = $clog2(2 * PF + 1);
    localparam int ADDR_W = (PF * FS > 1) ? $clog2(PF * FS) : 1;
    localparam int TW     = evg_pkg::TIME_W;
    localparam int FW     = evg_pkg::CMD_FIRST_W;
    localparam int LW     = evg_pkg::CMD_FILL_W;

    logic              r_gate_open, n_gate_open;
    logic [TW-1:0]     r_lvt, n_lvt;
    logic [7:0]        r_run, n_run;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_replay_busy, n_replay_busy;

    logic              accept;
    logic [15:0]       raw;
    logic [15:0]       mag;
    logic [SUM_W-1:0]  sum_acc;
    logic              frame_end;
    logic              voice;
    logic [TW-1:0]     elapsed;
    logic              hold_done;
    logic [SLOT_W-1:0] slot_inc;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]        run_inc;
    logic              open_now;
    logic [FSUM_W-1:0] first_sum;
    logic [SLOT_W-1:0] first_idx;

    assign o_ready = !i_q_full && (r_gate_open || !r_replay_busy);
    assign accept  = i_valid && o_ready;

    assign raw       = i_sample;
    assign mag       = raw[15] ? (~raw + 16'd1) : raw;
    assign sum_acc   = r_sum + SUM_W'(mag);
    assign frame_end = (r_pos == POS_W'(FS - 1));
    assign voice     = (sum_acc >= i_thr_scaled);
    assign elapsed   = i_time - r_lvt;
    assign hold_done = (elapsed >= {16'd0, i_hold});
    assign slot_inc  = (r_slot == SLOT_W'(PF - 1)) ? '0 : r_slot + SLOT_W'(1);
    assign fill_inc  = (r_fill == FILL_W'(PF)) ? r_fill : r_fill + FILL_W'(1);
    assign run_inc   = !voice ? 8'd0 : ((r_run == 8'hFF) ? r_run : r_run + 8'd1);
    assign open_now  = (run_inc >= i_debounce);
    assign first_sum = FSUM_W'(slot_inc) + FSUM_W'(PF) - FSUM_W'(fill_inc);
    assign first_idx = (first_sum >= FSUM_W'(PF)) ? SLOT_W'(first_sum - FSUM_W'(PF))
                                                 : SLOT_W'(first_sum);

    assign o_wr_addr = ADDR_W'(int'(r_slot) * FS + int'(r_pos));
    assign o_wr_data = raw;

    always_comb begin
        n_gate_open   = r_gate_open;
        n_lvt         = r_lvt;
        n_run         = r_run;
        n_slot        = r_slot;
        n_fill        = r_fill;
        n_sum         = r_sum;
        n_pos         = r_pos;
        n_replay_busy = r_replay_busy;
        o_push        = 1'b0;
        o_wr_en       = 1'b0;
        o_cmd.kind    = evg_pkg::CMD_PASS;
        o_cmd.sample  = raw;
        o_cmd.first   = FW'(first_idx);
        o_cmd.fill    = LW'(fill_inc);

        if (i_replay_done) begin
            n_replay_busy = 1'b0;
        end

        if (accept) begin
            n_sum = frame_end ? '0 : sum_acc;
            n_pos = frame_end ? '0 : r_pos + POS_W'(1);
            if (r_gate_open) begin
                o_push = 1'b1;
                if (frame_end) begin
                    if (voice) begin
                        n_lvt = i_time;
                    end else if (hold_done) begin
                        n_gate_open = 1'b0;
                        n_run       = '0;
                        n_fill      = '0;
                        n_slot      = '0;
                    end
                end
            end else begin
                o_wr_en = 1'b1;
                if (frame_end) begin
                    n_slot = slot_inc;
                    n_fill = fill_inc;
                    n_run  = run_inc;
                    if (open_now) begin
                        n_gate_open   = 1'b1;
                        n_lvt         = i_time;
                        n_run         = '0;
                        n_fill        = '0;
                        n_slot        = '0;
                        n_replay_busy = 1'b1;
                        o_push        = 1'b1;
                        o_cmd.kind    = evg_pkg::CMD_REPLAY;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_open   <= 1'b1;
            r_lvt         <= '0;
            r_run         <= '0;
            r_slot        <= '0;
            r_fill        <= '0;
            r_sum         <= '0;
            r_pos         <= '0;
            r_replay_busy <= 1'b0;
        end else begin
            r_gate_open   <= n_gate_open;
            r_lvt         <= n_lvt;
            r_run         <= n_run;
            r_slot        <= n_slot;
            r_fill        <= n_fill;
            r_sum         <= n_sum;
            r_pos         <= n_pos;
            r_replay_busy <= n_replay_busy;
        end
    end

    `EVG_ASSERT(a_no_ring_write_in_replay, i_clk, i_rst_n, o_wr_en |-> !r_replay_busy)
    `EVG_ASSERT(a_fill_bounded, i_clk, i_rst_n, r_fill <= FILL_W'(PF))

endmodule

// ----- rtl/evg_back.sv -----
//------------------------------------------------------------------------------
// Voice gate back end
// Takes commands from the queue, drives the output register and replays the
// preroll ring by reading it one sample at a time.
//------------------------------------------------------------------------------
`include "energy_voice_gate_with_preroll_unit_defines.svh"

module evg_back #(
    parameter int FS = 16,
    parameter int PF = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    output logic                                 o_pop,
    input  evg_pkg::t_cmd                        i_cmd,
    output logic                                 o_rd_en,
    output logic [(PF*FS > 1 ? $clog2(PF*FS) : 1)-1:0] o_rd_addr,
    input  logic [evg_pkg::SAMPLE_W-1:0]         i_rd_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [evg_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                 o_replayed,
    output logic                                 o_last,
    output logic                                 o_replay_done
);

    localparam int DEPTH  = PF * FS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int REM_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (PF > 1) ? $clog2(PF) : 1;
    localparam int FILL_W = $clog2(PF + 1);
    localparam int SW     = evg_pkg::SAMPLE_W;

    evg_pkg::t_back_state r_state, n_state;
    logic [ADDR_W-1:0]    r_addr;
    logic [REM_W-1:0]     r_remain;
    logic                 r_out_valid;
    logic [SW-1:0]        r_out_sample;
    logic                 r_out_replayed;
    logic                 r_out_last;

    logic out_free;
    logic final_sample;
    logic load;
    logic load_replayed;
    logic load_last;
    logic start_replay;
    logic step;

    assign out_free     = !r_out_valid || i_ready;
    assign final_sample = (r_remain == REM_W'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            evg_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free && (i_cmd.kind == evg_pkg::CMD_REPLAY)) begin
                    n_state = evg_pkg::BK_READ;
                end
            end
            evg_pkg::BK_READ: begin
                n_state = evg_pkg::BK_EMIT;
            end
            evg_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = final_sample ? evg_pkg::BK_IDLE : evg_pkg::BK_READ;
                end
            end
            default: begin
                n_state = evg_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop         = 1'b0;
        o_rd_en       = 1'b0;
        load          = 1'b0;
        load_replayed = 1'b0;
        load_last     = 1'b0;
        start_replay  = 1'b0;
        step          = 1'b0;
        o_replay_done = 1'b0;
        unique case (r_state)
            evg_pkg::BK_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop = 1'b1;
                    if (i_cmd.kind == evg_pkg::CMD_PASS) begin
                        load      = 1'b1;
                        load_last = 1'b1;
                    end else begin
                        start_replay = 1'b1;
                    end
                end
            end
            evg_pkg::BK_READ: begin
                o_rd_en = 1'b1;
            end
            evg_pkg::BK_EMIT: begin
                if (out_free) begin
                    load          = 1'b1;
                    load_replayed = 1'b1;
                    load_last     = final_sample;
                    step          = 1'b1;
                    o_replay_done = final_sample;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd_addr = r_addr;

    always_ff @(posedge i_clk) begin
        if (start_replay) begin
            r_addr   <= ADDR_W'(int'(i_cmd.first[SLOT_W-1:0]) * FS);
            r_remain <= REM_W'(int'(i_cmd.fill[FILL_W-1:0]) * FS);
        end else if (step) begin
            r_addr   <= (r_addr == ADDR_W'(DEPTH - 1)) ? '0 : r_addr + ADDR_W'(1);
            r_remain <= r_remain - REM_W'(1);
        end
        if (load) begin
            r_out_sample   <= load_replayed ? i_rd_data : i_cmd.sample;
            r_out_replayed <= load_replayed;
            r_out_last     <= load_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= evg_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_sample   = $signed(r_out_sample);
    assign o_replayed = r_out_replayed;
    assign o_last     = r_out_last;

    `EVG_ASSERT(a_emit_has_samples, i_clk, i_rst_n,
        (r_state == evg_pkg::BK_EMIT) |-> (r_remain != '0))
    `EVG_ASSERT_NORST(a_reset_to_idle, i_clk, !i_rst_n |=> (r_state == evg_pkg::BK_IDLE))

endmodule

// ----- rtl/energy_voice_gate_with_preroll_unit.sv -----
//------------------------------------------------------------------------------
// Energy voice gate with preroll
// Frame energy voice detector that gates an audio stream and replays the
// frames recorded just before the gate opened.
//------------------------------------------------------------------------------
// Samples enter on the s_axis channel (sample and 48-bit millisecond time) and
// leave on the m_axis channel; tuser marks replayed samples and tlast marks the
// final result caused by one input sample. Registers must be written over the APB
// port only while the block is idle; the block itself does not enforce this.
// While the gate is open every sample is passed on through the command queue to
// the output register, one sample per cycle while m_axis_tready stays high. While
// the gate is closed, samples are written into the preroll RAM and give no result.
// On the frame end that opens the gate, fill * FRAME_SAMPLES samples are replayed
// from the RAM oldest first, each in a read state and then an emit state for its
// registered read; input stays accepted during a replay while the gate remains
// open, and is held off when a closed gate would write the RAM before it ends.
// A four-entry command queue between the classifier and the output register lets
// input keep flowing while m_axis_tready is low, until the queue fills.
// Reset leaves the gate open, all counters at zero and the registers at their
// defaults; the preroll RAM is not cleared and needs no clearing pass.
//------------------------------------------------------------------------------
module energy_voice_gate_with_preroll_unit #(
    parameter int FRAME_SAMPLES  = 16,
    parameter int PREROLL_FRAMES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] sample, [63:16] time_ms
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] out_sample
    output logic [15:0] m_axis_tdata,
    // [0] replayed
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FS     = FRAME_SAMPLES;
    localparam int PF     = PREROLL_FRAMES;
    localparam int DEPTH  = PF * FS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W  = 16 + $clog2(FS + 1);

    logic [15:0]      r_thr;
    logic [SUM_W-1:0] r_thr_scaled;
    logic [31:0]      r_hold;
    logic [7:0]       r_debounce;
    logic             cfg_write;

    evg_pkg::t_cmd    push_cmd;
    evg_pkg::t_cmd    pop_cmd;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    logic             wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]      wr_data;
    logic             rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]      rd_data;
    logic             replay_done;
    logic signed [15:0] out_sample;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr        <= 16'd256;
            r_thr_scaled <= SUM_W'(256 * FS);
            r_hold       <= 32'd1000;
            r_debounce   <= 8'd2;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                evg_pkg::REG_THRESHOLD: begin
                    r_thr        <= pwdata[15:0];
                    r_thr_scaled <= SUM_W'(int'(pwdata[15:0]) * FS);
                end
                evg_pkg::REG_HOLD: begin
                    r_hold <= pwdata;
                end
                evg_pkg::REG_DEBOUNCE: begin
                    r_debounce <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            evg_pkg::REG_THRESHOLD: prdata = {16'd0, r_thr};
            evg_pkg::REG_HOLD:      prdata = r_hold;
            evg_pkg::REG_DEBOUNCE:  prdata = {24'd0, r_debounce};
            default:                prdata = '0;
        endcase
    end

    evg_front #(
        .FS (FS),
        .PF (PF)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_sample      ($signed(s_axis_tdata[15:0])),
        .i_time        (s_axis_tdata[63:16]),
        .i_thr_scaled  (r_thr_scaled),
        .i_hold        (r_hold),
        .i_debounce    (r_debounce),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .i_replay_done (replay_done)
    );

    evg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    evg_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    evg_back #(
        .FS (FS),
        .PF (PF)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .o_pop         (q_pop),
        .i_cmd         (pop_cmd),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_sample      (out_sample),
        .o_replayed    (m_axis_tuser),
        .o_last        (m_axis_tlast),
        .o_replay_done (replay_done)
    );

    assign m_axis_tdata = out_sample;

endmodule

// ----- verif/energy_voice_gate_checker.sv -----
//------------------------------------------------------------------------------
// Voice gate output checker
// Watches the register port and both sample channels of the voice gate. It
// models the frame energy detector, the hold timer and the preroll ring, and
// builds the expected output samples for every accepted request. Each output
// sample is then compared field by field with the oldest expected one.
//------------------------------------------------------------------------------
module energy_voice_gate_checker #(
    parameter int FRAME_SAMPLES  = 16,
    parameter int PREROLL_FRAMES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [63:0] i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,
    input  logic        i_out_user,
    input  logic        i_out_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending
);

    localparam int SW     = evg_pkg::SAMPLE_W;
    localparam int TW     = evg_pkg::TIME_W;
    localparam int POS_W  = $clog2(FRAME_SAMPLES);
    localparam int SLOT_W = $clog2(PREROLL_FRAMES);
    localparam int FILL_W = $clog2(PREROLL_FRAMES + 1);
    localparam int SUM_W  = SW + POS_W;

    typedef struct packed {
        logic [SW-1:0] smp;
        logic          replayed;
        logic          last;
    } t_gate_sample;

    t_gate_sample        expected_out_q[$];

    logic [15:0]         threshold;
    logic [31:0]         hold_ms;
    logic [7:0]          debounce;

    logic                gate_open;
    logic [TW-1:0]       voice_mark_ms;
    logic [7:0]          voice_run;
    logic [SLOT_W-1:0]   ring_wr;
    logic [FILL_W-1:0]   ring_fill;
    logic [SW-1:0]       ring_store [PREROLL_FRAMES*FRAME_SAMPLES];
    logic [SUM_W-1:0]    frame_sum;
    logic [POS_W-1:0]    frame_pos;

    task automatic push_expected(input logic [SW-1:0] smp, input logic replayed,
                                 input logic last);
        t_gate_sample item;
        item.smp      = smp;
        item.replayed = replayed;
        item.last     = last;
        expected_out_q.push_back(item);
    endtask

    task automatic flag_mismatch(input string what);
        if (o_mismatches < 10) begin
            $display("%s", what);
        end
        o_mismatches++;
    endtask

    task automatic predict_gate_sample(input logic [SW-1:0] smp,
                                       input logic [TW-1:0] now_ms);
        logic [SW-1:0]       mag;
        logic                voice;
        logic [SLOT_W-1:0]   first_slot;
        logic [SLOT_W-1:0]   slot;
        mag = smp[SW-1] ? (~smp + 1'b1) : smp;
        frame_sum = frame_sum + SUM_W'(mag);
        if (gate_open) begin
            push_expected(smp, 1'b0, 1'b1);
        end else begin
            ring_store[ring_wr * FRAME_SAMPLES + frame_pos] = smp;
        end
        if (frame_pos != POS_W'(FRAME_SAMPLES - 1)) begin
            frame_pos = frame_pos + 1'b1;
            return;
        end
        voice = (frame_sum / FRAME_SAMPLES) >= SUM_W'(threshold);
        frame_sum = '0;
        frame_pos = '0;
        if (gate_open) begin
            if (voice) begin
                voice_mark_ms = now_ms;
            end else if (TW'(now_ms - voice_mark_ms) >= TW'(hold_ms)) begin
                gate_open = 1'b0;
                voice_run = '0;
                ring_fill = '0;
                ring_wr   = '0;
            end
            return;
        end
        ring_wr = ring_wr + 1'b1;
        if (ring_fill < PREROLL_FRAMES) begin
            ring_fill = ring_fill + 1'b1;
        end
        if (!voice) begin
            voice_run = '0;
        end else if (voice_run != 8'hFF) begin
            voice_run = voice_run + 1'b1;
        end
        if (voice_run < debounce) begin
            return;
        end
        // The replay runs oldest frame first and ends with the frame just closed.
        gate_open     = 1'b1;
        voice_mark_ms = now_ms;
        voice_run     = '0;
        first_slot    = ring_wr - SLOT_W'(ring_fill);
        for (int f = 0; f < ring_fill; f++) begin
            slot = first_slot + SLOT_W'(f);
            for (int j = 0; j < FRAME_SAMPLES; j++) begin
                push_expected(ring_store[slot * FRAME_SAMPLES + j], 1'b1,
                              (f == ring_fill - 1) && (j == FRAME_SAMPLES - 1));
            end
        end
        ring_fill = '0;
        ring_wr   = '0;
    endtask

    always @(posedge i_clk) begin
        t_gate_sample want;
        if (!i_rst_n) begin
            threshold     = 16'd256;
            hold_ms       = 32'd1000;
            debounce      = 8'd2;
            gate_open     = 1'b1;
            voice_mark_ms = '0;
            voice_run     = '0;
            ring_wr       = '0;
            ring_fill     = '0;
            frame_sum     = '0;
            frame_pos     = '0;
            expected_out_q.delete();
            o_mismatches  = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    evg_pkg::REG_THRESHOLD: threshold = i_pwdata[15:0];
                    evg_pkg::REG_HOLD:      hold_ms   = i_pwdata;
                    evg_pkg::REG_DEBOUNCE:  debounce  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_gate_sample(i_in_data[15:0], i_in_data[63:16]);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_out_q.size() == 0) begin
                    flag_mismatch($sformatf(
                        "unexpected output: sample %h replayed %0d last %0d",
                        i_out_data, i_out_user, i_out_last));
                end else begin
                    want = expected_out_q.pop_front();
                    if (want.smp !== i_out_data || want.replayed !== i_out_user ||
                            want.last !== i_out_last) begin
                        flag_mismatch($sformatf(
                            {"output mismatch: expected sample %h replayed %0d last %0d,",
                             " got sample %h replayed %0d last %0d"},
                            want.smp, want.replayed, want.last,
                            i_out_data, i_out_user, i_out_last));
                    end
                end
            end
        end
        o_pending = expected_out_q.size();
    end

endmodule

// ----- verif/tb.sv -----
//------------------------------------------------------------------------------
// Voice gate testbench
// Drives audio frames through the voice gate over several register settings:
// pass-through, gate closing on quiet frames, preroll recording with ring
// wrap, debounced opening with replay, and the threshold, hold and debounce
// extremes. Both channels idle at random and the output side holds off once
// long enough to stall the input. A separate checker predicts every output.
//------------------------------------------------------------------------------
module tb;

    localparam int FRAME_SAMPLES   = 16;
    localparam int PREROLL_FRAMES  = 4;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int SETTLE_CYCLES   = 16;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        FRM_QUIET,
        FRM_LOUD,
        FRM_NOISE
    } t_frame_kind;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          chk_mismatches;
    int          chk_pending;
    logic        idle_on;
    logic        hold_off_req;
    int          cur_threshold;
    logic [47:0] t_now;
    logic [15:0] corner_samples [8] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                       16'h0001, 16'h5555, 16'hAAAA, 16'h8001};

    energy_voice_gate_with_preroll_unit #(
        .FRAME_SAMPLES  (FRAME_SAMPLES),
        .PREROLL_FRAMES (PREROLL_FRAMES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    energy_voice_gate_checker #(
        .FRAME_SAMPLES  (FRAME_SAMPLES),
        .PREROLL_FRAMES (PREROLL_FRAMES)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (chk_mismatches),
        .o_pending    (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [47:0] rand_time();
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [15:0] pick_sample(input t_frame_kind kind);
        int mag;
        case (kind)
            FRM_LOUD: begin
                if ($urandom_range(3, 0) == 0) mag = cur_threshold;
                else mag = $urandom_range(32768, cur_threshold);
            end
            FRM_QUIET: begin
                if ($urandom_range(3, 0) == 0) mag = cur_threshold - 1;
                else mag = $urandom_range(cur_threshold - 1, 0);
            end
            default: return 16'($urandom);
        endcase
        if (mag == 32768) return 16'h8000;
        return $urandom_range(1, 0) ? 16'(-mag) : 16'(mag);
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic [15:0] smp, input logic [47:0] tms);
        while (idle_on && $urandom_range(99, 0) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tms, smp};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input t_frame_kind kind, input logic [47:0] end_ms);
        for (int k = 0; k < FRAME_SAMPLES; k++) begin
            send_item(pick_sample(kind), (k == FRAME_SAMPLES - 1) ? end_ms : rand_time());
        end
    endtask

    // A gated frame gives no output, so the block may still be busy after the
    // last expected output; the settle time covers that.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= !(idle_on && $urandom_range(99, 0) < 16);
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        idle_on       = 1'b0;
        hold_off_req  = 1'b0;
        cur_threshold = 256;
        t_now         = 48'd5000;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sample and time extremes with the reset settings; the gate is open.
        for (int k = 0; k < FRAME_SAMPLES; k++) begin
            send_item((k < 8) ? corner_samples[k] : 16'($urandom),
                      (k == 0) ? 48'd0 : (k == 1) ? 48'hFFFF_FFFF_FFFF :
                      (k == FRAME_SAMPLES - 1) ? t_now : rand_time());
        end
        wait_drained();

        // Zero hold closes on a quiet frame; zero debounce opens on the next.
        write_reg(evg_pkg::REG_THRESHOLD, 32'h00AB_0100);
        write_reg(evg_pkg::REG_HOLD, 32'd0);
        write_reg(evg_pkg::REG_DEBOUNCE, 32'h1234_5600);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cur_threshold = 256;
        t_now = t_now + 48'($urandom_range(2000, 1));
        send_frame(FRM_QUIET, t_now);
        t_now = t_now + 48'($urandom_range(2000, 1));
        send_frame($urandom_range(1, 0) ? FRM_QUIET : FRM_NOISE, t_now);
        wait_drained();

        // Zero threshold keeps the gate open while the output side holds off.
        idle_on = 1'b1;
        write_reg(evg_pkg::REG_THRESHOLD, 32'd0);
        write_reg(evg_pkg::REG_HOLD, 32'hFFFF_FFFF);
        write_reg(evg_pkg::REG_DEBOUNCE, 32'd1);
        cur_threshold = 0;
        hold_off_req = 1'b1;
        t_now = t_now + 48'($urandom_range(2000, 1));
        send_frame(FRM_NOISE, t_now);
        wait_drained();

        // A time that runs backward closes the gate despite the longest hold. A
        // broken voice run and a ring wrap come before the opening replay.
        write_reg(evg_pkg::REG_THRESHOLD, 32'd32768);
        write_reg(evg_pkg::REG_DEBOUNCE, 32'd2);
        cur_threshold = 32768;
        send_frame(FRM_QUIET, t_now - 48'($urandom_range(1000, 1)));
        send_frame(FRM_LOUD, rand_time());
        send_frame(FRM_NOISE, rand_time());
        send_frame(FRM_QUIET, rand_time());
        send_frame(FRM_LOUD, rand_time());
        t_now = t_now + 48'($urandom_range(2000, 1));
        send_frame(FRM_LOUD, t_now);
        wait_drained();

        // The largest debounce keeps the gate closed after it shuts.
        cur_threshold = $urandom_range(32768, 1);
        write_reg(evg_pkg::REG_THRESHOLD, 32'(cur_threshold));
        write_reg(evg_pkg::REG_HOLD, 32'd0);
        write_reg(evg_pkg::REG_DEBOUNCE, 32'd255);
        send_frame(FRM_QUIET, rand_time());
        send_frame(FRM_LOUD, rand_time());
        wait_drained();

        if (chk_mismatches == 0 && chk_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
